// ----- src/wav_pkg.sv -----
package wav_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RIFF  = 3'd1,
    ST_NOT_WAVE  = 3'd2,
    ST_FMT_SMALL = 3'd3,
    ST_NOT_PCM   = 3'd4,
    ST_NO_FMT    = 3'd5,
    ST_TRUNC     = 3'd6
  } status_e;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [31:0] FmtBodyLen = 32'd16;
  localparam logic [15:0] FmtTagPcm  = 16'd1;

  typedef struct packed {
    logic [31:0] data_length;
    logic [15:0] bits_per_sample;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    status_e     status;
  } result_t;

endpackage

// ----- src/wav_pcm_header_parser_core.sv -----
// Parses the header of a RIFF/WAVE PCM file that arrives one byte per input word, little
// endian, and gives one result word per file: either status ok with the channel count, sample
// rate, bits per sample and data chunk length, or an error code (not RIFF, not WAVE, fmt
// chunk too small, not PCM, data chunk before fmt, truncated) with all other fields zero. The
// block takes one byte every cycle while input ready is high; each byte passes through compare
// and counter logic into the parse state, and a result is registered in the cycle after the
// byte that completes it. Results go out through a two-word buffer (output register plus skid
// register), so input ready drops only while both hold a word not yet taken. After a result the
// remaining bytes of the file are dropped; an input word with tlast set ends the file, gives a
// truncated error if no result was given yet, and rearms the parser. Sample data is not passed.
module wav_pcm_header_parser_core
  import wav_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // stream_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,   // channel_count, sample_rate, bits_per_sample, data_length
  output logic [2:0]   m_axis_tuser_o    // status
);

  typedef enum logic [3:0] {
    PH_RIFF_TAG  = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_WAVE_TAG  = 4'd2,
    PH_CHUNK_HDR = 4'd3,
    PH_FMT_BODY  = 4'd4,
    PH_SKIP      = 4'd5,
    PH_DONE      = 4'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic [32:0] skip_q, skip_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [15:0] fmt_tag_q, fmt_tag_d;

  logic        accept;
  logic        res_valid;
  status_e     res_status;
  logic [31:0] res_len;
  result_t     res_word;
  logic [32:0] skip_start;
  logic        skip_load;

  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;

  logic [7:0]  b;

  assign b      = s_axis_tdata_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_d      = tag_q;
    size_d     = size_q;
    skip_d     = skip_q;
    fmt_seen_d = fmt_seen_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    fmt_tag_d  = fmt_tag_q;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_len    = 32'd0;
    skip_start = 33'd0;
    skip_load  = 1'b0;

    if (accept) begin
      if (s_axis_tlast_i) begin
        if (phase_q != PH_DONE) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNC;
        end
        phase_d    = PH_RIFF_TAG;
        pos_d      = 5'd0;
        tag_d      = 32'd0;
        size_d     = 32'd0;
        skip_d     = 33'd0;
        fmt_seen_d = 1'b0;
        chan_d     = 16'd0;
        rate_d     = 32'd0;
        bits_d     = 16'd0;
        fmt_tag_d  = 16'd0;
      end else begin
        case (phase_q)
          PH_RIFF_TAG, PH_WAVE_TAG: begin
            tag_d = {b, tag_q[31:8]};
            pos_d = pos_q + 5'd1;
            if (pos_q >= 5'd3) begin
              pos_d = 5'd0;
              if (phase_q == PH_RIFF_TAG) begin
                if (tag_d != TagRiff) begin
                  res_valid  = 1'b1;
                  res_status = ST_NOT_RIFF;
                end else begin
                  phase_d = PH_RIFF_SIZE;
                end
              end else begin
                if (tag_d != TagWave) begin
                  res_valid  = 1'b1;
                  res_status = ST_NOT_WAVE;
                end else begin
                  phase_d = PH_CHUNK_HDR;
                end
              end
            end
          end
          PH_RIFF_SIZE: begin
            pos_d = pos_q + 5'd1;
            if (pos_q >= 5'd3) begin
              pos_d   = 5'd0;
              phase_d = PH_WAVE_TAG;
            end
          end
          PH_CHUNK_HDR: begin
            if (pos_q < 5'd4) begin
              tag_d = {b, tag_q[31:8]};
            end else begin
              size_d = {b, size_q[31:8]};
            end
            pos_d = pos_q + 5'd1;
            if (pos_q >= 5'd7) begin
              pos_d = 5'd0;
              if (tag_d == TagFmt) begin
                if (size_d < FmtBodyLen) begin
                  res_valid  = 1'b1;
                  res_status = ST_FMT_SMALL;
                end else begin
                  fmt_tag_d = 16'd0;
                  phase_d   = PH_FMT_BODY;
                end
              end else if (tag_d == TagData) begin
                res_valid  = 1'b1;
                res_status = fmt_seen_q ? ST_OK : ST_NO_FMT;
                res_len    = size_d;
              end else begin
                skip_start = {1'b0, size_d} + {32'd0, size_d[0]};
                skip_load  = 1'b1;
              end
            end
          end
          PH_FMT_BODY: begin
            if (pos_q < 5'd2) begin
              fmt_tag_d = {b, fmt_tag_q[15:8]};
            end else if (pos_q < 5'd4) begin
              chan_d = {b, chan_q[15:8]};
            end else if (pos_q < 5'd8) begin
              rate_d = {b, rate_q[31:8]};
            end else if (pos_q >= 5'd14) begin
              bits_d = {b, bits_q[15:8]};
            end
            pos_d = pos_q + 5'd1;
            if (pos_q >= 5'd15) begin
              if (fmt_tag_d != FmtTagPcm) begin
                res_valid  = 1'b1;
                res_status = ST_NOT_PCM;
              end else begin
                fmt_seen_d = 1'b1;
                skip_start = {1'b0, size_q} - {1'b0, FmtBodyLen};
                skip_load  = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            if (skip_q != 33'd0) begin
              skip_d = skip_q - 33'd1;
            end
            if (skip_d == 33'd0) begin
              pos_d   = 5'd0;
              phase_d = PH_CHUNK_HDR;
            end
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase

        if (skip_load) begin
          skip_d  = skip_start;
          pos_d   = 5'd0;
          phase_d = (skip_start == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
        end
        if (res_valid) begin
          phase_d = PH_DONE;
        end
      end
    end
  end

  always_comb begin
    res_word        = '0;
    res_word.status = res_status;
    if (res_status == ST_OK) begin
      res_word.channel_count   = chan_q;
      res_word.sample_rate     = rate_q;
      res_word.bits_per_sample = bits_q;
      res_word.data_length     = res_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_RIFF_TAG;
      pos_q        <= 5'd0;
      tag_q        <= 32'd0;
      size_q       <= 32'd0;
      skip_q       <= 33'd0;
      fmt_seen_q   <= 1'b0;
      chan_q       <= 16'd0;
      rate_q       <= 32'd0;
      bits_q       <= 16'd0;
      fmt_tag_q    <= 16'd0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      tag_q      <= tag_d;
      size_q     <= size_d;
      skip_q     <= skip_d;
      fmt_seen_q <= fmt_seen_d;
      chan_q     <= chan_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      fmt_tag_q  <= fmt_tag_d;
      if (!out_valid_q || m_axis_tready_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      out_q <= skid_valid_q ? skid_q : res_word;
    end else if (res_valid) begin
      skid_q <= res_word;
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.data_length, out_q.bits_per_sample,
                            out_q.sample_rate, out_q.channel_count};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> (m_axis_tdata_o == 96'd0))
    else $error("error word carries nonzero fields");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && !(accept && s_axis_tlast_i)) |=> (phase_q == PH_DONE))
    else $error("parser left done phase without end word");

  a_one_result_per_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && !(accept && s_axis_tlast_i)) |-> !res_valid)
    else $error("second result in one file");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import wav_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxReports = 10;

  typedef enum logic [3:0] {
    AT_RIFF_TAG,
    AT_RIFF_SIZE,
    AT_WAVE_TAG,
    AT_CHUNK_HEAD,
    AT_FMT_BODY,
    AT_SKIP,
    AT_DONE
  } hdr_phase_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;  // data_byte
  logic        s_axis_tlast_i  = 1'b0;   // stream_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;           // channel_count, sample_rate, bits_per_sample, data_length
  logic [2:0]  m_axis_tuser_o;           // status

  wav_pcm_header_parser_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // parser shadow state
  hdr_phase_e  ph;
  logic [4:0]  pos;
  logic [31:0] tag_sr;
  logic [31:0] size_sr;
  logic [32:0] skip_cnt;
  logic        fmt_seen;
  logic [15:0] keep_ch;
  logic [31:0] keep_rate;
  logic [15:0] keep_bits;
  logic [15:0] fmt_tag_sr;

  result_t     expected_results[$];
  result_t     got_res;
  result_t     want_res;
  logic [7:0]  file_bytes[$];

  int          fail_count  = 0;
  int          cycle_count = 0;
  int          word_count  = 0;
  int          hold_left   = 0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;

  function automatic void clear_parser();
    ph         = AT_RIFF_TAG;
    pos        = '0;
    tag_sr     = '0;
    size_sr    = '0;
    skip_cnt   = '0;
    fmt_seen   = 1'b0;
    keep_ch    = '0;
    keep_rate  = '0;
    keep_bits  = '0;
    fmt_tag_sr = '0;
  endfunction

  function automatic void post_result(status_e st, logic [31:0] len);
    result_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.channel_count   = keep_ch;
      r.sample_rate     = keep_rate;
      r.bits_per_sample = keep_bits;
      r.data_length     = len;
    end
    expected_results.push_back(r);
    ph = AT_DONE;
  endfunction

  function automatic void start_skip(logic [32:0] n);
    skip_cnt = n;
    pos      = '0;
    ph       = (n == 33'd0) ? AT_CHUNK_HEAD : AT_SKIP;
  endfunction

  function automatic void parse_word(logic [7:0] b, logic last);
    logic [4:0] p;
    p = pos;
    if (last) begin
      if (ph != AT_DONE) post_result(ST_TRUNC, '0);
      clear_parser();
    end else begin
      case (ph)
        AT_RIFF_TAG, AT_WAVE_TAG: begin
          tag_sr = {b, tag_sr[31:8]};
          pos    = p + 5'd1;
          if (p >= 5'd3) begin
            pos = '0;
            if (ph == AT_RIFF_TAG) begin
              if (tag_sr != TagRiff) post_result(ST_NOT_RIFF, '0);
              else ph = AT_RIFF_SIZE;
            end else begin
              if (tag_sr != TagWave) post_result(ST_NOT_WAVE, '0);
              else ph = AT_CHUNK_HEAD;
            end
          end
        end
        AT_RIFF_SIZE: begin
          pos = p + 5'd1;
          if (p >= 5'd3) begin
            pos = '0;
            ph  = AT_WAVE_TAG;
          end
        end
        AT_CHUNK_HEAD: begin
          if (p < 5'd4) tag_sr = {b, tag_sr[31:8]};
          else size_sr = {b, size_sr[31:8]};
          pos = p + 5'd1;
          if (p >= 5'd7) begin
            pos = '0;
            if (tag_sr == TagFmt) begin
              if (size_sr < FmtBodyLen) begin
                post_result(ST_FMT_SMALL, '0);
              end else begin
                fmt_tag_sr = '0;
                ph         = AT_FMT_BODY;
              end
            end else if (tag_sr == TagData) begin
              if (!fmt_seen) post_result(ST_NO_FMT, '0);
              else post_result(ST_OK, size_sr);
            end else begin
              start_skip({1'b0, size_sr} + {32'd0, size_sr[0]});
            end
          end
        end
        AT_FMT_BODY: begin
          if (p < 5'd2) fmt_tag_sr = {b, fmt_tag_sr[15:8]};
          else if (p < 5'd4) keep_ch = {b, keep_ch[15:8]};
          else if (p < 5'd8) keep_rate = {b, keep_rate[31:8]};
          else if (p >= 5'd14) keep_bits = {b, keep_bits[15:8]};
          pos = p + 5'd1;
          if (p >= 5'd15) begin
            if (fmt_tag_sr != FmtTagPcm) begin
              post_result(ST_NOT_PCM, '0);
            end else begin
              fmt_seen = 1'b1;
              start_skip({1'b0, size_sr} - {1'b0, FmtBodyLen});
            end
          end
        end
        AT_SKIP: begin
          if (skip_cnt != 33'd0) skip_cnt = skip_cnt - 33'd1;
          if (skip_cnt == 33'd0) begin
            pos = '0;
            ph  = AT_CHUNK_HEAD;
          end
        end
        default: begin
          ph = AT_DONE;
        end
      endcase
    end
  endfunction

  // file builders
  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_riff_wave();
    put_le(TagRiff, 4);
    put_le($urandom, 4);
    put_le(TagWave, 4);
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] size);
    put_le(tag, 4);
    put_le(size, 4);
    for (int i = 0; i < size + size[0]; i++) put_le($urandom, 1);
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] ftag, logic [15:0] ch,
                                  logic [31:0] rate, logic [15:0] bits);
    put_le(TagFmt, 4);
    put_le(size, 4);
    put_le({16'd0, ftag}, 2);
    put_le({16'd0, ch}, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'd0, bits}, 2);
    for (int i = 16; i < size; i++) put_le($urandom, 1);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (tx_idle_en && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_word(b, last);
    word_count++;
  endtask

  task automatic send_file(input logic with_end);
    foreach (file_bytes[i]) send_word(file_bytes[i], 1'b0);
    if (with_end) send_word(8'($urandom_range(255)), 1'b1);
    file_bytes.delete();
  endtask

  task automatic random_file();
    int kind;
    int spot;
    int cut;
    logic [31:0] fsize;
    logic [31:0] dlen;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise, sometimes behind a valid preamble
      if (kind < 4) put_riff_wave();
      repeat ($urandom_range(1, 12)) put_le($urandom, 1);
    end else begin
      put_riff_wave();
      repeat ($urandom_range(0, 2)) put_chunk($urandom, $urandom_range(0, 9));
      if ($urandom_range(9) != 0) begin
        fsize = ($urandom_range(19) == 0) ? $urandom_range(0, 15) : 16 + $urandom_range(0, 4);
        put_fmt(fsize, ($urandom_range(9) == 0) ? 16'($urandom) : FmtTagPcm,
                16'($urandom), $urandom, 16'($urandom));
      end
      repeat ($urandom_range(0, 1)) put_chunk($urandom, $urandom_range(0, 9));
      case ($urandom_range(9))
        0:       dlen = 32'd0;
        1:       dlen = 32'hFFFF_FFFF;
        default: dlen = $urandom;
      endcase
      put_le(TagData, 4);
      put_le(dlen, 4);
      repeat ($urandom_range(0, 3)) put_le($urandom, 1);
      if (kind < 22) begin
        spot = $urandom_range(0, file_bytes.size() - 1);
        file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
      end else if (kind < 32) begin
        cut = $urandom_range(0, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end
    send_file(1'b1);
  endtask

  task automatic test_tag_checks();
    send_word(8'hFF, 1'b1);
    put_le(32'h5846_4952, 4);
    put_le(32'h0000_FFFF, 3);
    send_file(1'b1);
    put_le(TagRiff, 4);
    put_le(32'h0, 4);
    put_le(32'h4656_4157, 4);
    send_file(1'b1);
    put_le(TagRiff, 3);
    send_file(1'b1);
  endtask

  task automatic test_fmt_checks();
    put_riff_wave();
    put_le(TagFmt, 4);
    put_le(32'd15, 4);
    send_file(1'b1);
    put_riff_wave();
    put_fmt(32'd16, 16'd3, 16'd2, 32'd48000, 16'd16);
    send_file(1'b1);
    put_riff_wave();
    put_le(TagFmt, 4);
    put_le(32'd16, 4);
    put_le(32'h0001_0001, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    send_file(1'b1);
    put_riff_wave();
    put_chunk(32'h5453_494C, 32'd3);
    put_le(TagData, 4);
    put_le(32'd8, 4);
    send_file(1'b1);
  endtask

  task automatic test_valid_files();
    put_riff_wave();
    put_fmt(32'd16, FmtTagPcm, 16'd1, 32'd44100, 16'd16);
    put_le(TagData, 4);
    put_le(32'd0, 4);
    send_file(1'b1);
    put_riff_wave();
    put_fmt(32'd18, FmtTagPcm, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_chunk(32'h4B4E_554A, 32'd0);
    put_chunk(32'h7473_6166, 32'd5);
    put_le(TagData, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le($urandom, 2);
    send_file(1'b1);
    // second fmt chunk overrides the first
    put_riff_wave();
    put_fmt(32'd16, FmtTagPcm, 16'd2, 32'd8000, 16'd8);
    put_fmt(32'd20, FmtTagPcm, 16'd0, 32'd0, 16'd0);
    put_le(TagData, 4);
    put_le(32'd1, 4);
    send_file(1'b1);
    // end between chunks, then format must not carry over
    put_riff_wave();
    put_fmt(32'd16, FmtTagPcm, 16'd6, 32'd96000, 16'd24);
    send_file(1'b1);
    put_riff_wave();
    put_le(TagData, 4);
    put_le(32'd4, 4);
    send_file(1'b1);
    // end inside huge skip regions
    put_riff_wave();
    put_le(32'h4B4E_554A, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le($urandom, 4);
    send_file(1'b1);
    put_riff_wave();
    put_fmt(32'd16, FmtTagPcm, 16'd1, 32'd1, 16'd1);
    file_bytes[16] = 8'hFF;
    file_bytes[17] = 8'hFF;
    file_bytes[18] = 8'hFF;
    file_bytes[19] = 8'hFF;
    put_le($urandom, 2);
    send_file(1'b1);
  endtask

  task automatic test_random_files();
    int start;
    start = word_count;
    while (word_count < start + 60) begin
      random_file();
    end
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (4) random_file();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    repeat (30) send_word(8'($urandom_range(255)), 1'b1);
    repeat (1) random_file();
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(rx_idle_en && $urandom_range(99) < 15);
    end
  end

  task automatic report_failure(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("%0t %s: exp st=%0d ch=%h rate=%h bits=%h len=%h", $realtime, what,
               want.status, want.channel_count, want.sample_rate, want.bits_per_sample,
               want.data_length);
      $display("%0t %s: got st=%0d ch=%h rate=%h bits=%h len=%h", $realtime, what,
               got.status, got.channel_count, got.sample_rate, got.bits_per_sample,
               got.data_length);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_res.status          = status_e'(m_axis_tuser_o);
      got_res.channel_count   = m_axis_tdata_o[15:0];
      got_res.sample_rate     = m_axis_tdata_o[47:16];
      got_res.bits_per_sample = m_axis_tdata_o[63:48];
      got_res.data_length     = m_axis_tdata_o[95:64];
      if (expected_results.size() == 0) begin
        report_failure("unexpected word", '0, got_res);
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.status !== want_res.status ||
            got_res.channel_count !== want_res.channel_count ||
            got_res.sample_rate !== want_res.sample_rate ||
            got_res.bits_per_sample !== want_res.bits_per_sample ||
            got_res.data_length !== want_res.data_length) begin
          report_failure("word mismatch", want_res, got_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("wav_pcm_header_parser_core verification failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tag_checks();
    test_fmt_checks();
    test_valid_files();
    test_random_files();
    test_no_idle();
    test_backpressure();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("wav_pcm_header_parser_core verification clean");
    end else begin
      $display("wav_pcm_header_parser_core verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/wav_pkg.sv
src/wav_pcm_header_parser_core.sv
tb/tb.sv
